// ===== rtl/core/twwfe_pkg.sv =====
// Shared types, codes and the glyph table for the word-wrap font encoder.
// No dependencies; every other file refers to it by scoped names.
package twwfe_pkg;

   // Output codes
   localparam logic [6:0] GLYPH_SPACE = 7'd89;
   localparam logic [6:0] CMD_ROW1    = 7'h74;
   localparam logic [6:0] CMD_ROW2    = 7'h75;
   localparam logic [6:0] CMD_WAITKEY = 7'h7e;
   localparam logic [6:0] CMD_END     = 7'h7f;

   // Special input characters
   localparam logic [7:0] CHAR_SEP  = 8'd32;
   localparam logic [7:0] CHAR_NONE = 8'd0;

   // Control register map
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_WIDTH   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTPUT_LIMIT = 1'b1;
   localparam logic [4:0] LINE_WIDTH_RESET   = 5'd13;
   localparam logic [7:0] OUTPUT_LIMIT_RESET = 8'd240;

   // Word store and queue geometry
   localparam int unsigned STORE_DEPTH = 32;
   localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [6:0] code;
      logic       final_res;
   } rsp_type;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_SEP,
      KIND_GLYPH
   } kind_type;

   // One classified character as held in the queue
   typedef struct packed {
      kind_type   kind;
      logic [6:0] glyph;
      logic       last;
   } item_type;

   // Queue head as seen by the back end
   typedef struct packed {
      logic     valid;
      item_type item;
   } qhead_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_EG_CHK,
      BK_ROW_G,
      BK_PUT_G,
      BK_SPACE,
      BK_ROW_FL,
      BK_FL_RD,
      BK_FL_DATA,
      BK_LAST,
      BK_END
   } back_state_type;

   // ASCII to glyph code; anything without a glyph maps to the space glyph
   function automatic logic [6:0] glyph_of(input logic [7:0] ch);
      logic [6:0] g;
      g = GLYPH_SPACE;
      if (ch >= 8'd65 && ch <= 8'd90) begin
         g = 7'(ch - 8'd65);
      end else if (ch >= 8'd97 && ch <= 8'd122) begin
         g = 7'(8'd26 + (ch - 8'd97));
      end else if (ch >= 8'd48 && ch <= 8'd57) begin
         g = 7'(8'd52 + (ch - 8'd48));
      end else begin
         case (ch)
            8'd33:   g = 7'd62;
            8'd63:   g = 7'd63;
            8'd45:   g = 7'd64;
            8'd46:   g = 7'd65;
            8'd44:   g = 7'd66;
            8'd39:   g = 7'd81;
            default: g = GLYPH_SPACE;
         endcase
      end
      return g;
   endfunction

endpackage

// ===== rtl/core/twwfe_front.sv =====
// Front end: classifies incoming characters and queues them for the back end.
// Depends on twwfe_pkg (item types, glyph table, queue geometry).
module twwfe_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  twwfe_pkg::req_type  req_data,
   input  logic                pop,
   output twwfe_pkg::qhead_type head
);

   localparam int unsigned CntW = twwfe_pkg::QUEUE_PTR_W + 1;

   twwfe_pkg::item_type q_mem [twwfe_pkg::QUEUE_DEPTH];
   logic [twwfe_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [twwfe_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic push;
   logic do_pop;
   twwfe_pkg::item_type cls;

   // Classify the incoming character
   always_comb begin
      cls.glyph = twwfe_pkg::glyph_of(req_data.character);
      cls.last  = req_data.last;
      if (req_data.character == twwfe_pkg::CHAR_SEP) begin
         cls.kind = twwfe_pkg::KIND_SEP;
      end else if (req_data.character == twwfe_pkg::CHAR_NONE) begin
         cls.kind = twwfe_pkg::KIND_NONE;
      end else begin
         cls.kind = twwfe_pkg::KIND_GLYPH;
      end
   end

   assign req_stall = (cnt_ff == CntW'(twwfe_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign do_pop    = pop && (cnt_ff != '0);

   assign head.valid = (cnt_ff != '0);
   assign head.item  = q_mem[rd_ptr_ff];

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && do_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= cls;
      end
   end

endmodule

// ===== rtl/core/twwfe_back.sv =====
// Back end: word buffer, greedy wrap sequencer and output register.
// Depends on twwfe_pkg (codes, item types, sequencer states).
module twwfe_back #(
   parameter int MAX_LINE = 31
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [4:0]           line_width,
   input  logic [7:0]           output_limit,
   input  twwfe_pkg::qhead_type head,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output twwfe_pkg::rsp_type   rsp_data
);

   localparam logic [5:0] MaxLineW = 6'(MAX_LINE);

   twwfe_pkg::back_state_type state_ff, state_in;

   logic [5:0] wl_ff, wl_in;
   logic [4:0] col_ff, col_in;
   logic [1:0] row_ff, row_in;
   logic [7:0] cnt_ff, cnt_in;
   logic       pt_ff, pt_in;
   logic [6:0] g_ff, g_in;
   logic       last_ff, last_in;
   logic       ret_fl_ff, ret_fl_in;
   logic [5:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   twwfe_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [6:0] store_mem [twwfe_pkg::STORE_DEPTH];
   logic [6:0] rd_data_ff;
   logic       store_we;

   logic [5:0] width_now;
   logic       below;
   logic       slot_free;
   logic [5:0] wl_inc;
   logic [6:0] fit_sum;
   logic       overflow;
   logic       col_full;
   logic       flush_word;
   logic [1:0] row_step;
   logic [6:0] row_code;
   logic       emit;
   logic       counted;
   twwfe_pkg::rsp_type emit_data;
   twwfe_pkg::back_state_type ret_state;

   // Shared decision terms
   always_comb begin
      width_now  = ({1'b0, line_width} < MaxLineW) ? {1'b0, line_width} : MaxLineW;
      below      = cnt_ff < output_limit;
      slot_free  = !rsp_valid_ff || !rsp_stall;
      wl_inc     = wl_ff + 6'd1;
      fit_sum    = {2'b00, col_ff} + 7'd1 + {1'b0, wl_inc};
      overflow   = fit_sum > {1'b0, width_now};
      col_full   = {1'b0, col_ff} >= width_now;
      flush_word = !pt_ff && (wl_ff != '0) && below;
      row_step   = row_ff + 2'd1;
      ret_state  = ret_fl_ff ? twwfe_pkg::BK_FL_RD : twwfe_pkg::BK_LAST;
      case (row_step)
         2'd1:    row_code = twwfe_pkg::CMD_ROW1;
         2'd2:    row_code = twwfe_pkg::CMD_ROW2;
         default: row_code = twwfe_pkg::CMD_WAITKEY;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         twwfe_pkg::BK_IDLE: begin
            if (head.valid) begin
               case (head.item.kind)
                  twwfe_pkg::KIND_SEP: begin
                     state_in = flush_word ? twwfe_pkg::BK_SPACE : twwfe_pkg::BK_LAST;
                  end
                  twwfe_pkg::KIND_GLYPH: begin
                     if (pt_ff || (wl_ff == '0 && col_ff == '0)) begin
                        state_in = twwfe_pkg::BK_EG_CHK;
                     end else if (overflow && below) begin
                        state_in = twwfe_pkg::BK_ROW_FL;
                     end else begin
                        state_in = twwfe_pkg::BK_LAST;
                     end
                  end
                  default: state_in = twwfe_pkg::BK_LAST;
               endcase
            end
         end
         twwfe_pkg::BK_EG_CHK: begin
            if (!below) begin
               state_in = ret_state;
            end else if (col_full) begin
               state_in = twwfe_pkg::BK_ROW_G;
            end else begin
               state_in = twwfe_pkg::BK_PUT_G;
            end
         end
         twwfe_pkg::BK_ROW_G: begin
            if (slot_free) state_in = twwfe_pkg::BK_PUT_G;
         end
         twwfe_pkg::BK_PUT_G: begin
            if (slot_free) state_in = ret_state;
         end
         twwfe_pkg::BK_SPACE, twwfe_pkg::BK_ROW_FL: begin
            if (slot_free) state_in = twwfe_pkg::BK_FL_RD;
         end
         twwfe_pkg::BK_FL_RD: begin
            state_in = (idx_ff >= wl_ff) ? twwfe_pkg::BK_LAST : twwfe_pkg::BK_FL_DATA;
         end
         twwfe_pkg::BK_FL_DATA: state_in = twwfe_pkg::BK_EG_CHK;
         twwfe_pkg::BK_LAST: begin
            if (!last_ff) begin
               state_in = twwfe_pkg::BK_IDLE;
            end else begin
               state_in = flush_word ? twwfe_pkg::BK_SPACE : twwfe_pkg::BK_END;
            end
         end
         twwfe_pkg::BK_END: begin
            if (slot_free) state_in = twwfe_pkg::BK_IDLE;
         end
         default: state_in = twwfe_pkg::BK_IDLE;
      endcase
   end

   // Datapath updates and emitted results
   always_comb begin
      wl_in     = wl_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      cnt_in    = cnt_ff;
      pt_in     = pt_ff;
      g_in      = g_ff;
      last_in   = last_ff;
      ret_fl_in = ret_fl_ff;
      idx_in    = idx_ff;
      pop       = 1'b0;
      store_we  = 1'b0;
      emit      = 1'b0;
      counted   = 1'b0;
      emit_data.code      = g_ff;
      emit_data.final_res = 1'b0;
      case (state_ff)
         twwfe_pkg::BK_IDLE: begin
            if (head.valid) begin
               pop       = 1'b1;
               g_in      = head.item.glyph;
               last_in   = head.item.last;
               ret_fl_in = 1'b0;
               case (head.item.kind)
                  twwfe_pkg::KIND_SEP: begin
                     pt_in = 1'b0;
                     if (!flush_word) wl_in = '0;
                  end
                  twwfe_pkg::KIND_GLYPH: begin
                     if (!pt_ff) begin
                        if (wl_ff == '0 && col_ff == '0) begin
                           pt_in = 1'b1;
                        end else begin
                           store_we = 1'b1;
                           wl_in    = wl_inc;
                           if (overflow) begin
                              pt_in = 1'b1;
                              if (!below) wl_in = '0;
                           end
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         twwfe_pkg::BK_ROW_G, twwfe_pkg::BK_ROW_FL: begin
            if (slot_free) begin
               emit           = 1'b1;
               counted        = 1'b1;
               emit_data.code = row_code;
               col_in         = '0;
               row_in         = (row_step == 2'd3) ? 2'd0 : row_step;
               // only a word flush restarts from the first buffered glyph
               if (state_ff == twwfe_pkg::BK_ROW_FL) idx_in = '0;
            end
         end
         twwfe_pkg::BK_PUT_G: begin
            if (slot_free) begin
               emit    = 1'b1;
               counted = 1'b1;
               col_in  = col_ff + 5'd1;
            end
         end
         twwfe_pkg::BK_SPACE: begin
            if (slot_free) begin
               emit           = 1'b1;
               counted        = 1'b1;
               emit_data.code = twwfe_pkg::GLYPH_SPACE;
               col_in         = col_ff + 5'd1;
               idx_in         = '0;
            end
         end
         twwfe_pkg::BK_FL_RD: begin
            if (idx_ff >= wl_ff) wl_in = '0;
         end
         twwfe_pkg::BK_FL_DATA: begin
            g_in      = rd_data_ff;
            idx_in    = idx_ff + 6'd1;
            ret_fl_in = 1'b1;
         end
         twwfe_pkg::BK_END: begin
            if (slot_free) begin
               emit                = 1'b1;
               emit_data.code      = twwfe_pkg::CMD_END;
               emit_data.final_res = 1'b1;
               wl_in               = '0;
               col_in              = '0;
               row_in              = '0;
               pt_in               = 1'b0;
            end
         end
         default: ;
      endcase
      // Saturating count of counted results; the end command clears it
      if (counted && cnt_ff != 8'd255) begin
         cnt_in = cnt_ff + 8'd1;
      end
      if (state_ff == twwfe_pkg::BK_END && slot_free) begin
         cnt_in = '0;
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= twwfe_pkg::BK_IDLE;
         wl_ff        <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         cnt_ff       <= '0;
         pt_ff        <= 1'b0;
         ret_fl_ff    <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wl_ff        <= wl_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         cnt_ff       <= cnt_in;
         pt_ff        <= pt_in;
         ret_fl_ff    <= ret_fl_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      g_ff        <= g_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Word store: written on buffering, read one glyph per flush step
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[wl_ff[twwfe_pkg::STORE_AW-1:0]] <= head.item.glyph;
      end
      rd_data_ff <= store_mem[idx_ff[twwfe_pkg::STORE_AW-1:0]];
   end

`ifndef ASSERT_OFF
   // End command returns the text state to its start
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == twwfe_pkg::BK_END && slot_free) |=>
      (cnt_ff == '0 && row_ff == '0 && col_ff == '0 && wl_ff == '0 && !pt_ff))
      else $error("state not cleared after end command");

   // A glyph transfer into the output register advances the column
   a_glyph_col: assert property (@(posedge clock) disable iff (reset)
      (state_ff == twwfe_pkg::BK_PUT_G && slot_free) |=>
      (col_ff == $past(col_ff) + 5'd1))
      else $error("column did not advance on glyph");

   // The buffer never holds a full row between items
   a_wl_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == twwfe_pkg::BK_IDLE) |-> (wl_ff < 6'd31))
      else $error("word buffer too long between items");

   // New results only come from an emitting state
   a_emit_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |->
      ($past(state_ff) == twwfe_pkg::BK_ROW_G || $past(state_ff) == twwfe_pkg::BK_PUT_G ||
       $past(state_ff) == twwfe_pkg::BK_SPACE || $past(state_ff) == twwfe_pkg::BK_ROW_FL ||
       $past(state_ff) == twwfe_pkg::BK_END))
      else $error("result appeared outside an emitting state");
`endif

endmodule

// ===== rtl/core/text_word_wrap_font_encoder_unit.sv =====
// Top level of the word-wrap font encoder: control registers, front end, back end.
// Depends on twwfe_pkg, twwfe_front and twwfe_back.
//
//  channel  direction  handshake             payload
//  req_     in         req_valid/req_stall   req_data  (character, last)
//  rsp_     out        rsp_valid/rsp_stall   rsp_data  (code, final_res)
//  csr_     in         csr_wen               csr_index, csr_wdata
//
// A character that streams straight out goes through the back end's idle, check, transfer
// and last states; each buffered glyph released at a word flush takes the steps store read,
// latch, limit/column check and transfer, with a row change in front of the transfer when
// the row is full. The back-end sequencer and its single word-store read port set these steps.
// Reset is synchronous and active high; the store needs no clearing pass.
// A four-entry queue lets the front keep taking characters while rsp_ stalls.
module text_word_wrap_font_encoder_unit #(
   parameter int MAX_LINE = 31
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  twwfe_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output twwfe_pkg::rsp_type                   rsp_data,
   input  logic                                 csr_wen,
   input  logic [twwfe_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [7:0]                           csr_wdata
);

   logic [4:0] line_width_ff, line_width_in;
   logic [7:0] output_limit_ff, output_limit_in;
   twwfe_pkg::qhead_type head;
   logic pop;

   // Control register writes
   always_comb begin
      line_width_in   = line_width_ff;
      output_limit_in = output_limit_ff;
      if (csr_wen) begin
         case (csr_index)
            twwfe_pkg::CSR_LINE_WIDTH:   line_width_in   = csr_wdata[4:0];
            twwfe_pkg::CSR_OUTPUT_LIMIT: output_limit_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= twwfe_pkg::LINE_WIDTH_RESET;
         output_limit_ff <= twwfe_pkg::OUTPUT_LIMIT_RESET;
      end else begin
         line_width_ff   <= line_width_in;
         output_limit_ff <= output_limit_in;
      end
   end

   twwfe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .pop       (pop),
      .head      (head)
   );

   twwfe_back #(
      .MAX_LINE (MAX_LINE)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .line_width   (line_width_ff),
      .output_limit (output_limit_ff),
      .head         (head),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule

// ===== tb/tb_text_word_wrap_font_encoder_unit.sv =====
`timescale 1ns / 1ps
// Testbench for text_word_wrap_font_encoder_unit: a directed table, then random text
// under several line-width / output-limit settings, checked against a local wrap predictor.
// Depends on twwfe_pkg and the RTL top level only.
module tb_text_word_wrap_font_encoder_unit;

   localparam int LINE_CAP = 31;
   localparam int PHASE_ITEMS = 37;
   localparam int NUM_PHASES = 7;
   localparam int DRAIN_CYCLES = 80;
   localparam longint TIMEOUT_NS = 64'd20_000_000;

   typedef enum logic [1:0] {
      CHK_PREDICT,
      CHK_SILENT,
      CHK_SINGLE
   } row_check_type;

   typedef struct packed {
      logic [7:0]    ch;
      logic          last;
      row_check_type chk;
      logic [6:0]    code;
   } dir_row_type;

   // DUT connections, all inputs known from time zero
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   twwfe_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   twwfe_pkg::rsp_type rsp_data;
   logic csr_wen = 1'b0;
   logic [twwfe_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [7:0] csr_wdata = '0;

   // Wrap predictor state
   int wrap_width;
   int wrap_limit;
   logic [6:0] word_glyphs [twwfe_pkg::STORE_DEPTH];
   int held_glyphs;
   int col;
   int row_idx;
   int out_count;
   bit streaming;

   twwfe_pkg::rsp_type step_codes[$];
   twwfe_pkg::rsp_type glyph_expect_q[$];
   twwfe_pkg::req_type stim_q[$];
   int fail_count = 0;
   int stall_left = 0;
   bit quiet = 1'b0;

   int phase_width [NUM_PHASES] = '{1, 31, 7, 0, 31, 20, 10};
   int phase_limit [NUM_PHASES] = '{255, 255, 60, 30, 1, 0, 255};

   // Directed rows; a typed code only where it is obvious
   dir_row_type dir_rows [22] = '{
      '{8'd65,  1'b0, CHK_SINGLE,  7'd0},      // 'A' at column 0 streams out
      '{8'd122, 1'b0, CHK_SINGLE,  7'd51},     // 'z' continues the streamed word
      '{8'd32,  1'b0, CHK_SILENT,  7'd0},      // separator after a streamed word
      '{8'd48,  1'b0, CHK_PREDICT, 7'd0},      // digits get buffered
      '{8'd57,  1'b0, CHK_PREDICT, 7'd0},
      '{8'd32,  1'b0, CHK_PREDICT, 7'd0},      // flush: space then word
      '{8'd33,  1'b0, CHK_PREDICT, 7'd0},      // every punctuation glyph
      '{8'd63,  1'b0, CHK_PREDICT, 7'd0},
      '{8'd45,  1'b0, CHK_PREDICT, 7'd0},
      '{8'd46,  1'b0, CHK_PREDICT, 7'd0},
      '{8'd44,  1'b0, CHK_PREDICT, 7'd0},
      '{8'd39,  1'b0, CHK_PREDICT, 7'd0},
      '{8'd0,   1'b0, CHK_SILENT,  7'd0},      // empty character is dropped
      '{8'd255, 1'b0, CHK_PREDICT, 7'd0},      // no glyph: space glyph
      '{8'd128, 1'b0, CHK_PREDICT, 7'd0},      // word overflows the row
      '{8'd32,  1'b0, CHK_PREDICT, 7'd0},
      '{8'd90,  1'b0, CHK_PREDICT, 7'd0},
      '{8'd97,  1'b1, CHK_PREDICT, 7'd0},      // last with a buffered word
      '{8'd0,   1'b1, CHK_SINGLE,  twwfe_pkg::CMD_END},   // bare end of text
      '{8'd0,   1'b0, CHK_SILENT,  7'd0},
      '{8'd32,  1'b1, CHK_SINGLE,  twwfe_pkg::CMD_END},   // separator carrying last
      '{8'd127, 1'b1, CHK_PREDICT, 7'd0}       // glyphless char that is also last
   };

   text_word_wrap_font_encoder_unit #(
      .MAX_LINE (LINE_CAP)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------- wrap predictor ----------------

   function automatic logic [6:0] char_to_glyph(input logic [7:0] ch);
      logic [6:0] g;
      g = twwfe_pkg::GLYPH_SPACE;
      if (ch >= 8'd65 && ch <= 8'd90) begin
         g = 7'(ch - 8'd65);
      end else if (ch >= 8'd97 && ch <= 8'd122) begin
         g = 7'(ch - 8'd71);
      end else if (ch >= 8'd48 && ch <= 8'd57) begin
         g = 7'(ch + 8'd4);
      end else begin
         case (ch)
            8'd33: g = 7'd62;
            8'd63: g = 7'd63;
            8'd45: g = 7'd64;
            8'd46: g = 7'd65;
            8'd44: g = 7'd66;
            8'd39: g = 7'd81;
            default: g = twwfe_pkg::GLYPH_SPACE;
         endcase
      end
      return g;
   endfunction

   function automatic int row_cap();
      return (wrap_width < LINE_CAP) ? wrap_width : LINE_CAP;
   endfunction

   function automatic void emit_code(input logic [6:0] code, input logic fin, input bit counted);
      twwfe_pkg::rsp_type r;
      r.code = code;
      r.final_res = fin;
      step_codes.push_back(r);
      if (counted && out_count < 255) out_count++;
   endfunction

   // Row 0 -> 1 -> 2 -> page break back to 0
   function automatic void advance_row();
      row_idx = (row_idx + 1) & 3;
      col = 0;
      if (row_idx == 1) begin
         emit_code(twwfe_pkg::CMD_ROW1, 1'b0, 1'b1);
      end else if (row_idx == 2) begin
         emit_code(twwfe_pkg::CMD_ROW2, 1'b0, 1'b1);
      end else begin
         emit_code(twwfe_pkg::CMD_WAITKEY, 1'b0, 1'b1);
         row_idx = 0;
      end
   endfunction

   function automatic void place_glyph(input logic [6:0] g);
      if (out_count >= wrap_limit) return;
      if (col >= row_cap()) advance_row();
      emit_code(g, 1'b0, 1'b1);
      col = (col + 1) & 31;
   endfunction

   function automatic void space_and_flush();
      emit_code(twwfe_pkg::GLYPH_SPACE, 1'b0, 1'b1);
      col = (col + 1) & 31;
      for (int i = 0; i < held_glyphs && i < twwfe_pkg::STORE_DEPTH; i++)
         place_glyph(word_glyphs[i]);
      held_glyphs = 0;
   endfunction

   // Codes caused by one accepted character, left in step_codes
   function automatic void predict_char(input twwfe_pkg::req_type it);
      logic [6:0] g;
      step_codes.delete();
      if (it.character == twwfe_pkg::CHAR_SEP) begin
         if (!streaming && held_glyphs > 0 && out_count < wrap_limit) space_and_flush();
         held_glyphs = 0;
         streaming = 1'b0;
      end else if (it.character != twwfe_pkg::CHAR_NONE) begin
         g = char_to_glyph(it.character);
         if (streaming) begin
            place_glyph(g);
         end else if (held_glyphs == 0 && col == 0) begin
            streaming = 1'b1;
            place_glyph(g);
         end else begin
            word_glyphs[held_glyphs & 31] = g;
            held_glyphs++;
            // word no longer fits: new row, release buffer, stream the rest
            if (col + 1 + held_glyphs > row_cap()) begin
               if (out_count < wrap_limit) begin
                  advance_row();
                  for (int i = 0; i < held_glyphs && i < twwfe_pkg::STORE_DEPTH; i++)
                     place_glyph(word_glyphs[i]);
               end
               held_glyphs = 0;
               streaming = 1'b1;
            end
         end
      end
      if (it.last) begin
         if (!streaming && held_glyphs > 0 && out_count < wrap_limit) space_and_flush();
         emit_code(twwfe_pkg::CMD_END, 1'b1, 1'b0);
         held_glyphs = 0;
         col = 0;
         row_idx = 0;
         out_count = 0;
         streaming = 1'b0;
      end
   endfunction

   // ---------------- stimulus ----------------

   function automatic void push_item(input logic [7:0] ch, input logic lst);
      twwfe_pkg::req_type r;
      r.character = ch;
      r.last = lst;
      stim_q.push_back(r);
   endfunction

   function automatic logic [7:0] pick_char();
      logic [7:0] punct [6] = '{8'd33, 8'd63, 8'd45, 8'd46, 8'd44, 8'd39};
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 40) return 8'($urandom_range(97, 122));
      if (sel < 55) return 8'($urandom_range(65, 90));
      if (sel < 67) return 8'($urandom_range(48, 57));
      if (sel < 82) return punct[$urandom_range(0, 5)];
      return 8'($urandom_range(0, 255));
   endfunction

   // One text: mostly words and separators, sometimes noise or no end
   function automatic void add_text();
      int words;
      int len;
      int sel;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(3, 12))
            push_item(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
         return;
      end
      words = $urandom_range(1, 8);
      for (int w = 0; w < words; w++) begin
         sel = $urandom_range(0, 19);
         if (sel < 15) len = $urandom_range(1, 8);
         else if (sel < 19) len = $urandom_range(9, 20);
         else len = $urandom_range(21, 40);
         repeat (len) push_item(pick_char(), 1'b0);
         if (w < words - 1) begin
            sel = $urandom_range(0, 9);
            if (sel < 7) begin
               push_item(twwfe_pkg::CHAR_SEP, 1'b0);
            end else if (sel < 9) begin
               push_item(twwfe_pkg::CHAR_SEP, 1'b0);
               push_item(twwfe_pkg::CHAR_SEP, 1'b0);
            end else begin
               push_item(twwfe_pkg::CHAR_NONE, 1'b0);
               push_item(twwfe_pkg::CHAR_SEP, 1'b0);
            end
         end
      end
      case ($urandom_range(0, 4))
         0: push_item(twwfe_pkg::CHAR_NONE, 1'b1);
         1: push_item(twwfe_pkg::CHAR_SEP, 1'b1);
         2, 3: push_item(pick_char(), 1'b1);
         default: ;   // text left open
      endcase
   endfunction

   // One transfer on req_, then book what it should cause
   task automatic send_item(input twwfe_pkg::req_type it, input row_check_type chk,
                            input logic [6:0] want_code);
      int gap;
      bit taken;
      twwfe_pkg::rsp_type want;
      gap = 0;
      if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      predict_char(it);
      case (chk)
         CHK_PREDICT: foreach (step_codes[k]) glyph_expect_q.push_back(step_codes[k]);
         CHK_SINGLE: begin
            want.code = want_code;
            want.final_res = (want_code == twwfe_pkg::CMD_END);
            glyph_expect_q.push_back(want);
         end
         default: ;
      endcase
   endtask

   // Stop sending, let every expected code arrive, then let the block go quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (glyph_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [twwfe_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [7:0] val);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
      if (idx == twwfe_pkg::CSR_LINE_WIDTH) wrap_width = int'(val[4:0]);
      else wrap_limit = int'(val);
   endtask

   // ---------------- checking ----------------

   function automatic void note_fail(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%0t: %s", $time, msg);
   endfunction

   // Result side: random stall bursts, none in the quiet stretch
   always @(posedge clock) begin
      if (quiet) stall_left = 0;
      else if (stall_left == 0 && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 16);
      rsp_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
   end

   // Values at the falling edge are those the next rising edge transfers
   always @(negedge clock) begin
      twwfe_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (glyph_expect_q.size() == 0) begin
            note_fail($sformatf("unexpected transfer: code %0d final_res %0b",
                                rsp_data.code, rsp_data.final_res));
         end else begin
            want = glyph_expect_q.pop_front();
            if (rsp_data.code !== want.code)
               note_fail($sformatf("code: expected %0d, got %0d", want.code, rsp_data.code));
            if (rsp_data.final_res !== want.final_res)
               note_fail($sformatf("final_res: expected %0b, got %0b",
                                   want.final_res, rsp_data.final_res));
         end
      end
   end

   // ---------------- run ----------------

   initial begin
      twwfe_pkg::req_type it;
      wrap_width = int'(twwfe_pkg::LINE_WIDTH_RESET);
      wrap_limit = int'(twwfe_pkg::OUTPUT_LIMIT_RESET);
      held_glyphs = 0;
      col = 0;
      row_idx = 0;
      out_count = 0;
      streaming = 1'b0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table under reset settings
      foreach (dir_rows[i]) begin
         it.character = dir_rows[i].ch;
         it.last = dir_rows[i].last;
         send_item(it, dir_rows[i].chk, dir_rows[i].code);
      end
      settle();

      // random text, one setting per phase, last phase without idling
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph == NUM_PHASES - 1) quiet = 1'b1;
         write_reg(twwfe_pkg::CSR_LINE_WIDTH, 8'(phase_width[ph]));
         write_reg(twwfe_pkg::CSR_OUTPUT_LIMIT, 8'(phase_limit[ph]));
         stim_q.delete();
         while (stim_q.size() < PHASE_ITEMS) add_text();
         for (int k = 0; k < PHASE_ITEMS; k++) send_item(stim_q[k], CHK_PREDICT, 7'd0);
         settle();
      end

      if (fail_count == 0) begin
         $display("tb_text_word_wrap_font_encoder_unit: done, clean");
      end else begin
         $display("tb_text_word_wrap_font_encoder_unit: done, errors");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("tb_text_word_wrap_font_encoder_unit: done, errors");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/twwfe_pkg.sv
rtl/core/twwfe_front.sv
rtl/core/twwfe_back.sv
rtl/core/text_word_wrap_font_encoder_unit.sv
tb/tb_text_word_wrap_font_encoder_unit.sv
